// File: rtl/dhcp6ol_pkg.sv
// Shared types, codes and lookup for the DHCPv6 option locator.
package dhcp6ol_pkg;

	localparam int unsigned ADDR_W       = 3;
	localparam int unsigned DATA_W       = 32;
	localparam int unsigned FIFO_DEPTH   = 4;
	localparam int unsigned FIFO_PTR_W   = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0]  MSG_TYPE_RST = 8'd2;
	localparam logic        REG_MSG_TYPE = 1'b0;   // register index, from paddr[2]

	localparam logic [15:0] CODE_CLIENT_ID = 16'd1;
	localparam logic [15:0] CODE_IA_PD     = 16'd25;
	localparam logic [15:0] CODE_IA_PREFIX = 16'd26;
	localparam logic [15:0] CODE_STATUS    = 16'd13;

	localparam logic [2:0] KIND_CLIENT_ID = 3'd0;
	localparam logic [2:0] KIND_IA_PD     = 3'd1;
	localparam logic [2:0] KIND_IA_PREFIX = 3'd2;
	localparam logic [2:0] KIND_STATUS    = 3'd3;
	localparam logic [2:0] KIND_FINAL     = 3'd4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_TOO_SHORT = 3'd1;
	localparam logic [2:0] ST_WRONG_TYPE = 3'd2;
	localparam logic [2:0] ST_TRUNCATED = 3'd3;
	localparam logic [2:0] ST_TOO_LONG  = 3'd4;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_CODE_HI = 3'd1,
		PH_CODE_LO = 3'd2,
		PH_LEN_HI  = 3'd3,
		PH_LEN_LO  = 3'd4,
		PH_BODY    = 3'd5
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] option_offset;
		logic [15:0] option_length;
		logic [2:0]  parse_status;
		logic        is_final;
	} out_t;

	typedef struct packed {
		logic       hit;
		logic [2:0] kind;
	} kind_t;

	// Map an option code to its reported kind; hit low for codes not reported.
	function automatic kind_t kind_of(input logic [15:0] code);
		kind_t k;
		k.hit  = 1'b1;
		k.kind = KIND_CLIENT_ID;
		unique case (code)
			CODE_CLIENT_ID: k.kind = KIND_CLIENT_ID;
			CODE_IA_PD:     k.kind = KIND_IA_PD;
			CODE_IA_PREFIX: k.kind = KIND_IA_PREFIX;
			CODE_STATUS:    k.kind = KIND_STATUS;
			default:        k.hit  = 1'b0;
		endcase
		return k;
	endfunction

endpackage

// File: rtl/dhcpv6_option_locator.sv
// DHCPv6 option locator: byte-stream option walker with result queue.
//
// Usage: message bytes enter on the in channel (valid/ready), one byte per
// request, with last_byte set on the final byte. Results leave on the out
// channel: one result per reported option (Client ID, IA_PD, IA Prefix,
// Status Code) and a summary with is_final set after each message's last byte.
// expected_msg_type is written over the APB port at address 0; the user must
// write it only while idle, as the block itself does not enforce this.
// Latency: an accepted request is held in the input register and decoded from
// there into the result queue. Throughput: one byte per cycle while the queue
// has room for two results. Bytes are decoded by the input register and one
// layer of counter/compare logic into a four-entry result queue, which emits
// one result per cycle; a last byte closing a reported option header pushes
// two results. Stall: when the receiver holds out_ready low the queue fills,
// the input register holds, and in_ready drops; nothing is lost.
// Reset: all message state clears, the queue empties and expected_msg_type
// returns to 2 (ADVERTISE). Message state also clears after every last byte.
module dhcpv6_option_locator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  dhcp6ol_pkg::in_t                in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output dhcp6ol_pkg::out_t               out_data,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dhcp6ol_pkg::ADDR_W-1:0]  paddr,
	input  logic [dhcp6ol_pkg::DATA_W-1:0]  pwdata,
	output logic [dhcp6ol_pkg::DATA_W-1:0]  prdata,
	output logic                            pready
);
	import dhcp6ol_pkg::*;

	logic [7:0] msg_type_q;

	logic       v_s1;
	in_t        req_s1;
	logic       advance;

	logic [15:0] pos_q, pos_n;
	phase_t      phase_q, phase_n;
	logic [15:0] code_q, code_n;
	logic [15:0] remain_q, remain_n;
	logic [15:0] start_q, start_n;
	logic        mism_q, mism_n;
	logic        ovf_q, ovf_n;

	logic        opt_hit;
	kind_t       kind_lk;
	logic        truncated;
	logic [2:0]  status;
	out_t        opt_res, fin_res;

	out_t                  fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  pop;
	logic                  push_opt, push_fin;
	logic [FIFO_CNT_W-1:0] n_push;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MSG_TYPE) ? {{(DATA_W-8){1'b0}}, msg_type_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_type_q <= MSG_TYPE_RST;
		end else if (psel && penable && pwrite && paddr[2] == REG_MSG_TYPE) begin
			msg_type_q <= pwdata[7:0];
		end
	end

	// input register; advance only with room for two results
	assign advance  = v_s1 && (cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));
	assign in_ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1 <= in_data;
		end
	end

	// option walk
	always_comb begin
		pos_n    = pos_q;
		phase_n  = phase_q;
		code_n   = code_q;
		remain_n = remain_q;
		start_n  = start_q;
		mism_n   = mism_q;
		ovf_n    = ovf_q;
		opt_hit  = 1'b0;
		kind_lk  = kind_of(code_q);

		if (pos_q == 16'hFFFF) begin
			ovf_n = 1'b1;
		end else begin
			pos_n = pos_q + 16'd1;
		end

		if (!ovf_n) begin
			case (phase_q)
				PH_HEADER: begin
					if (pos_q == 16'd0 && req_s1.data_byte != msg_type_q)
						mism_n = 1'b1;
					if (pos_q == 16'd3)
						phase_n = PH_CODE_HI;
				end
				PH_CODE_HI: begin
					start_n = pos_q;
					code_n  = {req_s1.data_byte, 8'h00};
					phase_n = PH_CODE_LO;
				end
				PH_CODE_LO: begin
					code_n  = code_q | {8'h00, req_s1.data_byte};
					phase_n = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					remain_n = {req_s1.data_byte, 8'h00};
					phase_n  = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					remain_n = remain_q | {8'h00, req_s1.data_byte};
					opt_hit  = kind_lk.hit && !mism_q;
					phase_n  = (remain_n != 16'd0) ? PH_BODY : PH_CODE_HI;
				end
				PH_BODY: begin
					remain_n = remain_q - 16'd1;
					if (remain_n == 16'd0)
						phase_n = PH_CODE_HI;
				end
				default: begin
				end
			endcase
		end

		truncated = (phase_n == PH_CODE_LO) || (phase_n == PH_LEN_HI) ||
			(phase_n == PH_LEN_LO) || (phase_n == PH_BODY && remain_n != 16'd0);

		if (!ovf_n && pos_n < 16'd5)
			status = ST_TOO_SHORT;
		else if (mism_n)
			status = ST_WRONG_TYPE;
		else if (truncated)
			status = ST_TRUNCATED;
		else if (ovf_n)
			status = ST_TOO_LONG;
		else
			status = ST_OK;

		opt_res.kind          = kind_lk.kind;
		opt_res.option_offset = start_q;
		opt_res.option_length = remain_n;
		opt_res.parse_status  = ST_OK;
		opt_res.is_final      = 1'b0;

		fin_res.kind          = KIND_FINAL;
		fin_res.option_offset = 16'd0;
		fin_res.option_length = 16'd0;
		fin_res.parse_status  = status;
		fin_res.is_final      = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			phase_q  <= PH_HEADER;
			code_q   <= '0;
			remain_q <= '0;
			start_q  <= '0;
			mism_q   <= 1'b0;
			ovf_q    <= 1'b0;
		end else if (advance) begin
			if (req_s1.last_byte) begin
				pos_q    <= '0;
				phase_q  <= PH_HEADER;
				code_q   <= '0;
				remain_q <= '0;
				start_q  <= '0;
				mism_q   <= 1'b0;
				ovf_q    <= 1'b0;
			end else begin
				pos_q    <= pos_n;
				phase_q  <= phase_n;
				code_q   <= code_n;
				remain_q <= remain_n;
				start_q  <= start_n;
				mism_q   <= mism_n;
				ovf_q    <= ovf_n;
			end
		end
	end

	// result queue; the option result goes ahead of the summary
	assign push_opt  = advance && opt_hit;
	assign push_fin  = advance && req_s1.last_byte;
	assign n_push    = FIFO_CNT_W'(push_opt) + FIFO_CNT_W'(push_fin);
	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign out_data  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_opt) begin
			fifo_q[wr_ptr_q] <= opt_res;
			if (push_fin)
				fifo_q[wr_ptr_q + FIFO_PTR_W'(1)] <= fin_res;
		end else if (push_fin) begin
			fifo_q[wr_ptr_q] <= fin_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(n_push);
			if (pop)
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			cnt_q <= cnt_q + n_push - FIFO_CNT_W'(pop);
		end
	end

endmodule
